>>> rtl/lruc_pkg.sv
// Shared types and codes for the LRU cache with pinned handles.
// No dependencies.
`timescale 1ns / 1ps
package lruc_pkg;
    localparam int PW = 6;                       // slot pointer width, holds the empty marker
    localparam logic [PW-1:0] NIL = 6'd63;
    localparam logic [5:0] REFS_MAX = 6'd63;

    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_LOOKUP  = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;
    localparam logic [1:0] FN_ERASE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_FREED  = 1'b1;

    typedef struct packed {
        logic [1:0]    func;
        logic [63:0]   key;
        logic [31:0]   val;
        logic [15:0]   charge;
        logic [PW-1:0] handle;
    } t_cmd;
endpackage

>>> rtl/lruc_if.sv
// Handshake channels of the cache: command items in, result items out.
// No dependencies.
`timescale 1ns / 1ps
interface lruc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] item_value;
    logic [15:0] charge;
    logic [4:0]  slot_handle;
    modport source (output valid, func, key, item_value, charge, slot_handle, input ready);
    modport sink   (input valid, func, key, item_value, charge, slot_handle, output ready);
endinterface

interface lruc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic [63:0] key_out;
    logic [31:0] value_out;
    logic [20:0] usage_out;
    logic        last;
    modport source (output valid, kind, status, slot_out, key_out, value_out, usage_out, last,
                    input ready);
    modport sink   (input valid, kind, status, slot_out, key_out, value_out, usage_out, last,
                    output ready);
endinterface

>>> rtl/lruc_front.sv
// Front end: accepts command items, masks key and value, queues them for the engine.
// Depends on lruc_pkg and lruc_in_if.
`timescale 1ns / 1ps
module lruc_front #(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lruc_in_if.sink       s_in,
    output lruc_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import lruc_pkg::*;

    localparam logic [63:0] KMASK = (KEY_BITS >= 64) ? {64{1'b1}}
                                  : ((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [31:0] VMASK = (VALUE_BITS >= 32) ? {32{1'b1}}
                                  : ((32'd1 << VALUE_BITS) - 32'd1);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.func   = s_in.func;
        cmd_in.key    = s_in.key & KMASK;
        cmd_in.val    = s_in.item_value & VMASK;
        cmd_in.charge = s_in.charge;
        cmd_in.handle = {1'b0, s_in.slot_handle};
    end

    assign s_in.ready  = (r_cnt != 2'd2);
    assign push        = s_in.valid && s_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd_in;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/lruc_back.sv
// Engine: slot store, recency list, eviction and result sequencing.
// Depends on lruc_pkg and lruc_out_if.
`timescale 1ns / 1ps
module lruc_back #(
    parameter int ENTRIES    = 32,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lruc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  logic           i_cfg_we,
    input  logic [19:0]    i_cfg_data,
    lruc_out_if.source     m_out
);
    import lruc_pkg::*;

    localparam int SW = $clog2(ENTRIES);
    localparam int KB = KEY_BITS;
    localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int ND = ENTRIES + 2;
    localparam int NW = $clog2(ND);
    localparam int CW = $clog2(ND + 1);
    localparam logic [PW-1:0] ENT = PW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_DISP, S_ERASE, S_ALLOC, S_EVICT,
        S_LOOK, S_REL, S_RD, S_LD, S_OUT, S_ANS
    } t_state;

    typedef struct packed {
        logic [PW-1:0] slot;
        logic [KB-1:0] key;
        logic [VB-1:0] val;
    } t_note;

    t_state        r_state;
    t_state        r_ret;
    t_cmd          r_cmd;
    logic [19:0]   r_cap;
    logic [20:0]   r_usage;

    logic          r_used   [ENTRIES];
    logic          r_cached [ENTRIES];
    logic [KB-1:0] r_key    [ENTRIES];
    logic [VB-1:0] r_val    [ENTRIES];
    logic [15:0]   r_chg    [ENTRIES];
    logic [5:0]    r_refs   [ENTRIES];
    logic [PW-1:0] r_next   [ENTRIES];
    logic [PW-1:0] r_prev   [ENTRIES];
    logic [PW-1:0] r_head, r_tail;
    logic [ENTRIES-1:0] r_match;

    logic [PW-1:0] r_s;
    logic [1:0]    r_status;
    logic [PW-1:0] r_aslot;
    logic [VB-1:0] r_aval;

    t_note         r_nmem [ND];
    t_note         r_nq;
    logic [CW-1:0] r_ncnt, r_nrp;

    logic          r_ov, r_okind, r_olast;
    logic [1:0]    r_ostat;
    logic [PW-1:0] r_oslot;
    logic [KB-1:0] r_okey;
    logic [VB-1:0] r_oval;

    // combinational views
    logic [SW-1:0] s_idx, h_idx, fi_idx, p_idx, n_idx, t_idx;
    logic [5:0]    rs, rs_dec, rh;
    logic [PW-1:0] p, n, hit_s, free_s;
    logic          hit, has_free, bad, do_remove, nw;
    t_note         nw_data;

    always_comb begin
        s_idx  = r_s[SW-1:0];
        h_idx  = r_cmd.handle[SW-1:0];
        rs     = r_refs[s_idx];
        rs_dec = (rs == 6'd0) ? 6'd0 : rs - 6'd1;
        rh     = r_refs[h_idx];
        p      = r_prev[s_idx];
        n      = r_next[s_idx];
        p_idx  = p[SW-1:0];
        n_idx  = n[SW-1:0];
        t_idx  = r_tail[SW-1:0];
        hit    = 1'b0;
        hit_s  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit   = 1'b1;
                hit_s = PW'(i);
            end
        end
        has_free = 1'b0;
        free_s   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                has_free = 1'b1;
                free_s   = PW'(i);
            end
        end
        fi_idx = free_s[SW-1:0];
        bad = (r_cmd.handle >= ENT) || !r_used[h_idx] ||
              (r_cached[h_idx] && rh <= 6'd1) || (rh == 6'd0);
        do_remove = ((r_state == S_ERASE) || (r_state == S_LOOK)) && (rs == 6'd1);
        nw = ((r_state == S_ERASE) && (rs_dec == 6'd0)) ||
             ((r_state == S_REL) && !bad && (rh == 6'd1));
        if (r_state == S_REL) begin
            nw_data.slot = r_cmd.handle;
            nw_data.key  = r_key[h_idx];
            nw_data.val  = r_val[h_idx];
        end else begin
            nw_data.slot = r_s;
            nw_data.key  = r_key[s_idx];
            nw_data.val  = r_val[s_idx];
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);

    // freed-notice buffer, held until the step ends so all results carry final usage
    always_ff @(posedge i_clk) begin
        if (nw) r_nmem[r_ncnt[NW-1:0]] <= nw_data;
        r_nq <= r_nmem[r_nrp[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cap   <= '0;
            r_usage <= '0;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_ncnt  <= '0;
            r_nrp   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_used[i]   <= 1'b0;
                r_cached[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (nw) r_ncnt <= r_ncnt + CW'(1);
            if (do_remove) begin
                if (p < ENT) r_next[p_idx] <= n; else r_head <= n;
                if (n < ENT) r_prev[n_idx] <= p; else r_tail <= p;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_status <= ST_OK;
                        r_aslot  <= '0;
                        r_aval   <= '0;
                        r_state  <= (i_cmd.func == FN_RELEASE) ? S_REL : S_MATCH;
                    end
                end
                S_MATCH: begin
                    for (int i = 0; i < ENTRIES; i++)
                        r_match[i] <= r_used[i] && r_cached[i] &&
                                      (r_key[i] == r_cmd.key[KB-1:0]);
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_s <= hit_s;
                    case (r_cmd.func)
                        FN_INSERT: begin
                            r_ret   <= S_ALLOC;
                            r_state <= hit ? S_ERASE : S_ALLOC;
                        end
                        FN_LOOKUP: begin
                            if (hit) r_state <= S_LOOK;
                            else begin
                                r_status <= ST_MISS;
                                r_state  <= S_RD;
                            end
                        end
                        default: begin
                            r_ret <= S_RD;
                            if (hit) r_state <= S_ERASE;
                            else begin
                                r_status <= ST_MISS;
                                r_state  <= S_RD;
                            end
                        end
                    endcase
                end
                S_ERASE: begin
                    r_cached[s_idx] <= 1'b0;
                    r_usage         <= r_usage - 21'(r_chg[s_idx]);
                    r_refs[s_idx]   <= rs_dec;
                    if (rs_dec == 6'd0) r_used[s_idx] <= 1'b0;
                    r_state <= r_ret;
                end
                S_ALLOC: begin
                    if (!has_free) r_status <= ST_FULL;
                    else begin
                        r_used[fi_idx] <= 1'b1;
                        r_key[fi_idx]  <= r_cmd.key[KB-1:0];
                        r_val[fi_idx]  <= r_cmd.val[VB-1:0];
                        r_chg[fi_idx]  <= r_cmd.charge;
                        if (r_cap != 20'd0) begin
                            r_refs[fi_idx]   <= 6'd2;
                            r_cached[fi_idx] <= 1'b1;
                            r_usage          <= r_usage + 21'(r_cmd.charge);
                        end else begin
                            r_refs[fi_idx]   <= 6'd1;
                            r_cached[fi_idx] <= 1'b0;
                        end
                        r_aslot <= free_s;
                    end
                    r_state <= S_EVICT;
                end
                S_EVICT: begin
                    if ((r_usage > {1'b0, r_cap}) && (r_head < ENT)) begin
                        r_s     <= r_head;
                        r_ret   <= S_EVICT;
                        r_state <= S_ERASE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_LOOK: begin
                    if (rs < REFS_MAX) r_refs[s_idx] <= rs + 6'd1;
                    r_aslot <= r_s;
                    r_aval  <= r_val[s_idx];
                    r_state <= S_RD;
                end
                S_REL: begin
                    if (bad) r_status <= ST_BAD;
                    else begin
                        r_refs[h_idx] <= rh - 6'd1;
                        if (rh == 6'd1) begin
                            r_used[h_idx]   <= 1'b0;
                            r_cached[h_idx] <= 1'b0;
                        end else if (r_cached[h_idx] && rh == 6'd2) begin
                            // back into the recency list as newest
                            r_next[h_idx] <= NIL;
                            r_prev[h_idx] <= r_tail;
                            if (r_tail < ENT) r_next[t_idx] <= r_cmd.handle;
                            else r_head <= r_cmd.handle;
                            r_tail <= r_cmd.handle;
                        end
                    end
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_nrp != r_ncnt) r_state <= S_LD;
                    else begin
                        r_ov    <= 1'b1;
                        r_okind <= KIND_ANSWER;
                        r_ostat <= r_status;
                        r_oslot <= r_aslot;
                        r_okey  <= '0;
                        r_oval  <= r_aval;
                        r_olast <= 1'b1;
                        r_state <= S_ANS;
                    end
                end
                S_LD: begin
                    r_ov    <= 1'b1;
                    r_okind <= KIND_FREED;
                    r_ostat <= ST_OK;
                    r_oslot <= r_nq.slot;
                    r_okey  <= r_nq.key;
                    r_oval  <= r_nq.val;
                    r_olast <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_out.ready) begin
                        r_ov    <= 1'b0;
                        r_nrp   <= r_nrp + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_ANS: begin
                    if (m_out.ready) begin
                        r_ov    <= 1'b0;
                        r_nrp   <= '0;
                        r_ncnt  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid     = r_ov;
    assign m_out.kind      = r_okind;
    assign m_out.status    = r_ostat;
    assign m_out.slot_out  = r_oslot[4:0];
    assign m_out.key_out   = 64'(r_okey);
    assign m_out.value_out = 32'(r_oval);
    assign m_out.usage_out = r_usage;
    assign m_out.last      = r_olast;
endmodule

>>> rtl/lru_cache_with_pinning.sv
// Top level of the charge-budgeted LRU cache with pinned handles.
// Depends on lruc_pkg, lruc_if, lruc_front and lruc_back.
`timescale 1ns / 1ps
//  channel   dir  handshake        payload
//  s_in      in   valid/ready      func, key, item_value, charge, slot_handle
//  m_out     out  valid/ready      kind, status, slot_out, key_out, value_out,
//                                  usage_out, last
//  cfg       in   i_cfg_we only    i_cfg_data = capacity
//
//  Flow: the engine takes one item at a time. A duplicate key on insert is erased
//  first, and each evicted entry passes through the erase state. Freed notices go
//  out before the answer, read from the notice buffer. A 2-deep front queue keeps
//  accepting items meanwhile.
//  Reset: synchronous, active low; the store comes up empty with capacity 0.
//  Stalls: results hold until taken; the front queue stalls the input when full.
module lru_cache_with_pinning #(
    parameter int ENTRIES    = 32,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lruc_in_if.sink     s_in,
    lruc_out_if.source  m_out,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data
);
    import lruc_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    // front: accept items, mask key and value, and hold them in a short queue
    lruc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (s_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // back: slot store, recency list, eviction, result sequencing
    lruc_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .m_out       (m_out)
    );
endmodule
